// ===== rtl/gas_sensor_air_quality_grader_core_assert.svh =====
// assertion macros for the air quality grader core
`ifndef GAS_SENSOR_AIR_QUALITY_GRADER_CORE_ASSERT_SVH
`define GAS_SENSOR_AIR_QUALITY_GRADER_CORE_ASSERT_SVH

// same-cycle implication
`define GSAQG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GSAQG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/gsaqg_pkg.sv =====
// types, constants and sequencer program for the air quality grader
`default_nettype none

package gsaqg_pkg;

	localparam int SAMPLES_PER_AVERAGE = 64;
	localparam int ADC_BITS            = 12;
	localparam int AVG_SHIFT           = $clog2(SAMPLES_PER_AVERAGE);
	localparam int SUM_W               = ADC_BITS + AVG_SHIFT;
	localparam int CNT_W               = AVG_SHIFT;

	localparam int WLEN_W = 16;
	localparam int NUM_W  = 26;
	localparam int LOAD_W = 16;
	localparam int RS_W   = 24;
	localparam int ITER_W = $clog2(NUM_W + 1);
	localparam int PROD_W = RS_W + 7;

	localparam logic [RS_W-1:0] RS_MAX = {RS_W{1'b1}};

	localparam logic [WLEN_W-1:0] WLEN_RESET = 16'd15;
	localparam logic [NUM_W-1:0]  NUM_RESET  = 26'd15883636;
	localparam logic [LOAD_W-1:0] LOAD_RESET = 16'd2560;

	// ratio thresholds in hundredths
	localparam logic [PROD_W-1:0] RATIO_DEN   = 31'd100;
	localparam logic [PROD_W-1:0] FALL_HI     = 31'd85;
	localparam logic [PROD_W-1:0] FALL_MID    = 31'd77;
	localparam logic [PROD_W-1:0] FALL_LO     = 31'd69;
	localparam logic [PROD_W-1:0] RECOVER_LO  = 31'd72;
	localparam logic [PROD_W-1:0] RECOVER_MID = 31'd80;
	localparam logic [PROD_W-1:0] RECOVER_HI  = 31'd88;

	localparam int PADDR_W = 4;
	localparam logic [1:0] REG_WINDOW_LENGTH   = 2'd0;
	localparam logic [1:0] REG_RS_NUMERATOR    = 2'd1;
	localparam logic [1:0] REG_LOAD_RESISTANCE = 2'd2;

	typedef logic [2:0] op_t;
	localparam op_t OP_NOP  = 3'd0;
	localparam op_t OP_INIT = 3'd1;
	localparam op_t OP_DIV  = 3'd2;
	localparam op_t OP_RS   = 3'd3;
	localparam op_t OP_WIN  = 3'd4;
	localparam op_t OP_CMP  = 3'd5;
	localparam op_t OP_OUT  = 3'd6;

	typedef logic [1:0] cond_t;
	localparam cond_t C_NEVER    = 2'd0;
	localparam cond_t C_ALWAYS   = 2'd1;
	localparam cond_t C_NO_START = 2'd2;
	localparam cond_t C_LOOP     = 2'd3;

	typedef logic [2:0] step_t;
	localparam step_t STEP_IDLE = 3'd0;
	localparam step_t STEP_INIT = 3'd1;
	localparam step_t STEP_DIV  = 3'd2;
	localparam step_t STEP_RS   = 3'd3;
	localparam step_t STEP_WIN  = 3'd4;
	localparam step_t STEP_CMP  = 3'd5;
	localparam step_t STEP_OUT  = 3'd6;
	localparam step_t STEP_TAIL = 3'd7;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} ctrl_t;

	typedef struct packed {
		logic above_hi;
		logic above_mid;
		logic above_lo;
		logic below_lo;
		logic below_mid;
		logic below_hi;
	} band_t;

	// loop conditions: wait for start, divide loop, output register busy
	function automatic ctrl_t seq_rom(input step_t pc);
		ctrl_t c;
		c = '{op: OP_NOP, cond: C_ALWAYS, target: STEP_IDLE};
		case (pc)
			STEP_IDLE: c = '{op: OP_NOP,  cond: C_NO_START, target: STEP_IDLE};
			STEP_INIT: c = '{op: OP_INIT, cond: C_NEVER,    target: STEP_IDLE};
			STEP_DIV:  c = '{op: OP_DIV,  cond: C_LOOP,     target: STEP_DIV};
			STEP_RS:   c = '{op: OP_RS,   cond: C_NEVER,    target: STEP_IDLE};
			STEP_WIN:  c = '{op: OP_WIN,  cond: C_NEVER,    target: STEP_IDLE};
			STEP_CMP:  c = '{op: OP_CMP,  cond: C_NEVER,    target: STEP_IDLE};
			STEP_OUT:  c = '{op: OP_OUT,  cond: C_LOOP,     target: STEP_OUT};
			STEP_TAIL: c = '{op: OP_NOP,  cond: C_ALWAYS,   target: STEP_IDLE};
			default:   c = '{op: OP_NOP,  cond: C_ALWAYS,   target: STEP_IDLE};
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/gas_sensor_air_quality_grader_core.sv =====
// Gas sensor air quality grader. Samples are taken one per cycle and summed in
// groups of 64; the 64th sample of a group starts a microcoded sequence that
// divides the numerator by the truncated mean one quotient bit per cycle, then
// forms the resistance, updates the window, compares bands and grades. One
// result comes out per group. After the last sample of the group its valid rises
// once the output register is free, following one setup step, the 26 steps of
// the restoring divider, then the resistance, window, compare and output
// steps. One more step returns the sequencer to idle, so a group keeps it busy
// through any output stall too. Samples of the next group keep being taken
// meanwhile; only a sample that would close another group waits until the
// sequence has finished. No clearing pass follows reset.
`default_nettype none

`include "gas_sensor_air_quality_grader_core_assert.svh"

module gas_sensor_air_quality_grader_core
	import gsaqg_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [ADC_BITS-1:0] adc_sample,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [ADC_BITS-1:0]     mean_value,
	output logic [RS_W-1:0]         resistance,
	output logic [RS_W-1:0]         reference_max,
	output logic                    falling,
	output logic [1:0]              level,
	output logic                    window_restarted,
	output logic                    mean_zero
);

	logic [WLEN_W-1:0] window_length_q;
	logic [NUM_W-1:0]  rs_numerator_q;
	logic [LOAD_W-1:0] load_resistance_q;

	logic [SUM_W-1:0]    sample_sum_q;
	logic [CNT_W-1:0]    sample_count_q;
	logic [SUM_W-1:0]    sum_next;
	logic                in_accept;
	logic                last_sample;
	logic                start;

	step_t               pc_q;
	ctrl_t               ctrl;
	logic                jump;
	logic                busy;
	logic                out_busy;

	logic [ADC_BITS-1:0] mean_q;
	logic [ADC_BITS-1:0] rem_q;
	logic [NUM_W-1:0]    quo_q;
	logic [ITER_W-1:0]   iter_q;
	logic [ADC_BITS:0]   rem_shift;
	logic [ADC_BITS:0]   rem_diff;
	logic                rem_ge;

	logic [NUM_W-1:0]    q_minus_load;
	logic [RS_W-1:0]     rs_calc;
	logic [RS_W-1:0]     rs_q;
	logic                zero_q;
	logic                restart_q;

	logic [WLEN_W-1:0]   averages_q;
	logic [RS_W-1:0]     window_max_q;
	logic [RS_W-1:0]     ref_max_q;
	logic [RS_W-1:0]     prev_rs_q;
	logic [1:0]          grade_q;
	logic [1:0]          grade_next;
	logic                fall_q;
	band_t               band_q;
	band_t               band_calc;
	logic [PROD_W-1:0]   rs_scaled;
	logic [PROD_W-1:0]   ref_wide;

	logic                out_valid_q;
	logic [ADC_BITS-1:0] mean_value_q;
	logic [RS_W-1:0]     resistance_q;
	logic [RS_W-1:0]     reference_max_q;
	logic                falling_q;
	logic [1:0]          level_q;
	logic                window_restarted_q;
	logic                mean_zero_q;

	logic cfg_write;

	// configuration port
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		case (paddr[3:2])
			REG_WINDOW_LENGTH:   prdata = {{(32-WLEN_W){1'b0}}, window_length_q};
			REG_RS_NUMERATOR:    prdata = {{(32-NUM_W){1'b0}}, rs_numerator_q};
			REG_LOAD_RESISTANCE: prdata = {{(32-LOAD_W){1'b0}}, load_resistance_q};
			default:             prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q   <= WLEN_RESET;
			rs_numerator_q    <= NUM_RESET;
			load_resistance_q <= LOAD_RESET;
		end else if (cfg_write) begin
			case (paddr[3:2])
				REG_WINDOW_LENGTH:   window_length_q   <= pwdata[WLEN_W-1:0];
				REG_RS_NUMERATOR:    rs_numerator_q    <= pwdata[NUM_W-1:0];
				REG_LOAD_RESISTANCE: load_resistance_q <= pwdata[LOAD_W-1:0];
				default: ;
			endcase
		end
	end

	// sample accumulation
	assign busy        = (pc_q != STEP_IDLE);
	assign last_sample = (sample_count_q == CNT_W'(SAMPLES_PER_AVERAGE - 1));
	assign in_stall    = busy && last_sample;
	assign in_accept   = in_valid && !in_stall;
	assign start       = in_accept && last_sample;
	assign sum_next    = sample_sum_q + SUM_W'(adc_sample);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_sum_q   <= '0;
			sample_count_q <= '0;
		end else if (in_accept) begin
			if (last_sample) begin
				sample_sum_q   <= '0;
				sample_count_q <= '0;
			end else begin
				sample_sum_q   <= sum_next;
				sample_count_q <= sample_count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mean_q <= sum_next[AVG_SHIFT +: ADC_BITS];
		end
	end

	// sequencer
	assign ctrl     = seq_rom(pc_q);
	assign out_busy = out_valid_q && out_stall;

	always_comb begin
		jump = 1'b0;
		case (ctrl.cond)
			C_NEVER:    jump = 1'b0;
			C_ALWAYS:   jump = 1'b1;
			C_NO_START: jump = !start;
			C_LOOP:     jump = (ctrl.op == OP_DIV) ? (iter_q != ITER_W'(1)) : out_busy;
			default:    jump = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_IDLE;
		end else if (jump) begin
			pc_q <= ctrl.target;
		end else begin
			pc_q <= pc_q + step_t'(1);
		end
	end

	// divider datapath
	assign rem_shift = {rem_q, quo_q[NUM_W-1]};
	assign rem_diff  = rem_shift - {1'b0, mean_q};
	assign rem_ge    = (rem_shift >= {1'b0, mean_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
		end else if (ctrl.op == OP_INIT) begin
			iter_q <= ITER_W'(NUM_W);
		end else if (ctrl.op == OP_DIV) begin
			iter_q <= iter_q - ITER_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.op == OP_INIT) begin
			rem_q <= '0;
			quo_q <= rs_numerator_q;
		end else if (ctrl.op == OP_DIV) begin
			rem_q <= rem_ge ? rem_diff[ADC_BITS-1:0] : rem_shift[ADC_BITS-1:0];
			quo_q <= {quo_q[NUM_W-2:0], rem_ge};
		end
	end

	// resistance from quotient
	assign q_minus_load = quo_q - NUM_W'(load_resistance_q);

	always_comb begin
		if (quo_q <= NUM_W'(load_resistance_q)) begin
			rs_calc = '0;
		end else if (|q_minus_load[NUM_W-1:RS_W]) begin
			rs_calc = RS_MAX;
		end else begin
			rs_calc = q_minus_load[RS_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.op == OP_RS) begin
			zero_q <= (mean_q == '0);
			rs_q   <= (mean_q == '0) ? RS_MAX : rs_calc;
		end
	end

	// band compares by cross multiplication
	assign rs_scaled = PROD_W'(rs_q) * RATIO_DEN;
	assign ref_wide  = PROD_W'(ref_max_q);

	always_comb begin
		band_calc.above_hi  = rs_scaled > ref_wide * FALL_HI;
		band_calc.above_mid = rs_scaled > ref_wide * FALL_MID;
		band_calc.above_lo  = rs_scaled > ref_wide * FALL_LO;
		band_calc.below_lo  = rs_scaled < ref_wide * RECOVER_LO;
		band_calc.below_mid = rs_scaled < ref_wide * RECOVER_MID;
		band_calc.below_hi  = rs_scaled < ref_wide * RECOVER_HI;
	end

	always_ff @(posedge clk) begin
		if (ctrl.op == OP_CMP) begin
			band_q <= band_calc;
		end
	end

	always_comb begin
		grade_next = grade_q;
		if (fall_q) begin
			if (band_q.above_hi) begin
				grade_next = 2'd0;
			end else if (band_q.above_mid) begin
				grade_next = 2'd1;
			end else if (band_q.above_lo) begin
				grade_next = 2'd2;
			end else begin
				grade_next = 2'd3;
			end
		end else if (band_q.below_lo) begin
			grade_next = 2'd3;
		end else if (band_q.below_mid) begin
			if (grade_q > 2'd2) begin
				grade_next = grade_q - 2'd1;
			end
		end else if (band_q.below_hi) begin
			if (grade_q > 2'd1) begin
				grade_next = grade_q - 2'd1;
			end
		end else if (grade_q > 2'd0) begin
			grade_next = grade_q - 2'd1;
		end
	end

	// window tracking, trend and grade state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			averages_q   <= '0;
			window_max_q <= '0;
			ref_max_q    <= '0;
			prev_rs_q    <= '0;
			grade_q      <= '0;
			fall_q       <= 1'b0;
			restart_q    <= 1'b0;
		end else begin
			if (ctrl.op == OP_WIN) begin
				if (averages_q >= window_length_q) begin
					ref_max_q    <= window_max_q;
					window_max_q <= '0;
					averages_q   <= '0;
					restart_q    <= 1'b1;
				end else begin
					averages_q <= averages_q + WLEN_W'(1);
					restart_q  <= 1'b0;
					if (rs_q > window_max_q) begin
						window_max_q <= rs_q;
						if (rs_q > ref_max_q) begin
							ref_max_q <= rs_q;
						end
					end
				end
			end
			if (ctrl.op == OP_CMP) begin
				fall_q    <= (prev_rs_q > rs_q);
				prev_rs_q <= rs_q;
			end
			if (ctrl.op == OP_OUT && !out_busy) begin
				grade_q <= grade_next;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.op == OP_OUT && !out_busy) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.op == OP_OUT && !out_busy) begin
			mean_value_q       <= mean_q;
			resistance_q       <= rs_q;
			reference_max_q    <= ref_max_q;
			falling_q          <= fall_q;
			level_q            <= grade_next;
			window_restarted_q <= restart_q;
			mean_zero_q        <= zero_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign mean_value       = mean_value_q;
	assign resistance       = resistance_q;
	assign reference_max    = reference_max_q;
	assign falling          = falling_q;
	assign level            = level_q;
	assign window_restarted = window_restarted_q;
	assign mean_zero        = mean_zero_q;

	`GSAQG_ASSERT_NXT(a_start_runs, clk, arst_n, (pc_q == STEP_IDLE) && start, pc_q == STEP_INIT, "group start did not launch the sequence")
	`GSAQG_ASSERT_IMP(a_div_iter, clk, arst_n, pc_q == STEP_DIV, iter_q != '0, "divider step count ran out")
	`GSAQG_ASSERT_IMP(a_ref_covers, clk, arst_n, 1'b1, window_max_q <= ref_max_q, "window maximum above reference")
	`GSAQG_ASSERT_NXT(a_out_load, clk, arst_n, (pc_q == STEP_OUT) && !out_busy, out_valid_q && (pc_q == STEP_TAIL), "result not loaded")

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// testbench for the air quality grader core: directed and random sample groups
module tb_top
	import gsaqg_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 48;
	localparam int IDLE_PERCENT = 36;
	localparam int ADC_TOP = (1 << ADC_BITS) - 1;
	localparam logic [31:0] NUM_TOP = (1 << NUM_W) - 1;
	localparam logic [31:0] WLEN_TOP = (1 << WLEN_W) - 1;
	localparam logic [31:0] LOAD_TOP = (1 << LOAD_W) - 1;

	typedef enum logic [1:0] {LEVEL_CLEAN, LEVEL_LIGHT, LEVEL_MODERATE, LEVEL_HEAVY} level_t;

	typedef struct {
		logic [ADC_BITS-1:0] mean_value;
		logic [RS_W-1:0]     resistance;
		logic [RS_W-1:0]     reference_max;
		logic                falling;
		logic [1:0]          level;
		logic                window_restarted;
		logic                mean_zero;
	} grade_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic in_valid, in_stall;
	logic [ADC_BITS-1:0] adc_sample;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [ADC_BITS-1:0] mean_value;
	logic [RS_W-1:0] resistance, reference_max;
	logic falling;
	logic [1:0] level;
	logic window_restarted, mean_zero;

	// predictor state and register copies
	int unsigned acc_sum, acc_count, win_count, win_peak, ref_peak, last_rs;
	logic [1:0] grade_now;
	int unsigned cfg_window, cfg_numer, cfg_load;

	grade_result_t expected_grades[$];
	int failures = 0;
	int cycle_count = 0;
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	bit hold_request = 1'b0;
	int hold_left = 0;

	gas_sensor_air_quality_grader_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.adc_sample(adc_sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.mean_value(mean_value),
		.resistance(resistance),
		.reference_max(reference_max),
		.falling(falling),
		.level(level),
		.window_restarted(window_restarted),
		.mean_zero(mean_zero)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, expected_grades.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// -1, 0 or 1 as rs/peak is below, at or above pct hundredths
	function automatic int band_cmp(input int unsigned rs, input int unsigned peak,
			input int unsigned pct);
		longint unsigned lhs, rhs;
		lhs = rs;
		rhs = peak;
		lhs = lhs * RATIO_DEN;
		rhs = rhs * pct;
		if (lhs > rhs)
			return 1;
		else if (lhs < rhs)
			return -1;
		return 0;
	endfunction

	function automatic void accumulate_sample(input logic [ADC_BITS-1:0] sample);
		grade_result_t r;
		int unsigned mean, quot, rs;
		bit restart, fall;
		acc_sum += sample;
		acc_count++;
		if (acc_count < SAMPLES_PER_AVERAGE)
			return;
		mean = acc_sum / SAMPLES_PER_AVERAGE;
		acc_sum = 0;
		acc_count = 0;
		if (mean == 0) begin
			rs = RS_MAX;
		end else begin
			quot = cfg_numer / mean;
			if (quot <= cfg_load)
				rs = 0;
			else
				rs = quot - cfg_load;
			if (rs > RS_MAX)
				rs = RS_MAX;
		end
		restart = (win_count >= cfg_window);
		if (restart) begin
			ref_peak = win_peak;
			win_peak = 0;
			win_count = 0;
		end else begin
			win_count++;
			if (rs > win_peak) begin
				win_peak = rs;
				if (win_peak > ref_peak)
					ref_peak = win_peak;
			end
		end
		fall = (last_rs > rs);
		last_rs = rs;
		if (fall) begin
			if (band_cmp(rs, ref_peak, FALL_HI) > 0)
				grade_now = LEVEL_CLEAN;
			else if (band_cmp(rs, ref_peak, FALL_MID) > 0)
				grade_now = LEVEL_LIGHT;
			else if (band_cmp(rs, ref_peak, FALL_LO) > 0)
				grade_now = LEVEL_MODERATE;
			else
				grade_now = LEVEL_HEAVY;
		end else begin
			if (band_cmp(rs, ref_peak, RECOVER_LO) < 0) begin
				grade_now = LEVEL_HEAVY;
			end else if (band_cmp(rs, ref_peak, RECOVER_MID) < 0) begin
				if (grade_now > LEVEL_MODERATE)
					grade_now = grade_now - 2'd1;
			end else if (band_cmp(rs, ref_peak, RECOVER_HI) < 0) begin
				if (grade_now > LEVEL_LIGHT)
					grade_now = grade_now - 2'd1;
			end else begin
				if (grade_now > LEVEL_CLEAN)
					grade_now = grade_now - 2'd1;
			end
		end
		r.mean_value = mean[ADC_BITS-1:0];
		r.resistance = rs[RS_W-1:0];
		r.reference_max = ref_peak[RS_W-1:0];
		r.falling = fall;
		r.level = grade_now;
		r.window_restarted = restart;
		r.mean_zero = (mean == 0);
		expected_grades.push_back(r);
	endfunction

	function automatic void check_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			failures++;
		end
	endfunction

	always @(posedge clk) begin
		grade_result_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (expected_grades.size() == 0) begin
				$display("%0t: result with none expected, expected nothing, actual mean %0d",
					$time, mean_value);
				failures++;
			end else begin
				want = expected_grades.pop_front();
				check_field("mean_value", want.mean_value, mean_value);
				check_field("resistance", want.resistance, resistance);
				check_field("reference_max", want.reference_max, reference_max);
				check_field("falling", want.falling, falling);
				check_field("level", want.level, level);
				check_field("window_restarted", want.window_restarted, window_restarted);
				check_field("mean_zero", want.mean_zero, mean_zero);
			end
		end
	end

	// receiver: random stalls, or a counted hold-off on request
	always @(negedge clk) begin
		if (hold_request) begin
			hold_left = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !rx_steady && ($urandom_range(99) < IDLE_PERCENT);
		end
	end

	task automatic send_sample(input logic [ADC_BITS-1:0] sample);
		int gap;
		gap = 0;
		while (!tx_steady && $urandom_range(99) < IDLE_PERCENT)
			gap++;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		adc_sample <= sample;
		do @(posedge clk); while (in_stall !== 1'b0);
		accumulate_sample(sample);
	endtask

	task automatic send_flat_group(input int unsigned value);
		repeat (SAMPLES_PER_AVERAGE) send_sample(value[ADC_BITS-1:0]);
	endtask

	task automatic await_drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_grades.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic check_reg(input logic [1:0] idx, input logic [31:0] want);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata !== want) begin
			$display("%0t: register %0d readback, expected %0d, actual %0d",
				$time, idx, want, prdata);
			failures++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		case (idx)
			REG_WINDOW_LENGTH:   cfg_window = value & WLEN_TOP;
			REG_RS_NUMERATOR:    cfg_numer = value & NUM_TOP;
			REG_LOAD_RESISTANCE: cfg_load = value & LOAD_TOP;
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_WINDOW_LENGTH:   check_reg(idx, cfg_window);
			REG_RS_NUMERATOR:    check_reg(idx, cfg_numer);
			REG_LOAD_RESISTANCE: check_reg(idx, cfg_load);
			default: ;
		endcase
	endtask

	function automatic int unsigned mean_for_rs(input int unsigned rs);
		int unsigned m;
		m = cfg_numer / (rs + cfg_load);
		if (m < 1)
			m = 1;
		if (m > ADC_TOP)
			m = ADC_TOP;
		return m;
	endfunction

	task automatic test_register_reset();
		check_reg(REG_WINDOW_LENGTH, WLEN_RESET);
		check_reg(REG_RS_NUMERATOR, NUM_RESET);
		check_reg(REG_LOAD_RESISTANCE, LOAD_RESET);
	endtask

	task automatic test_zero_mean();
		send_flat_group(0);
		send_sample(63);
		repeat (SAMPLES_PER_AVERAGE - 1) send_sample(0);
	endtask

	task automatic test_extreme_samples();
		send_flat_group(ADC_TOP);
		for (int i = 0; i < SAMPLES_PER_AVERAGE; i++)
			send_sample((i % 2) ? ADC_TOP : 0);
		send_flat_group(1);
	endtask

	task automatic test_saturation_and_floor();
		await_drain();
		write_reg(REG_RS_NUMERATOR, NUM_TOP);
		write_reg(REG_LOAD_RESISTANCE, 0);
		send_flat_group(1);
		await_drain();
		write_reg(REG_RS_NUMERATOR, 0);
		send_flat_group(ADC_TOP);
		await_drain();
		write_reg(REG_RS_NUMERATOR, NUM_RESET);
		write_reg(REG_LOAD_RESISTANCE, LOAD_TOP);
		send_flat_group(ADC_TOP);
	endtask

	// zero window length restarts the window every group; the reference is zero from the second group on
	task automatic test_zero_reference();
		await_drain();
		write_reg(REG_WINDOW_LENGTH, 0);
		write_reg(REG_LOAD_RESISTANCE, 4000);
		send_flat_group(1000);
		send_flat_group(ADC_TOP);
		send_flat_group(ADC_TOP);
		send_flat_group(1000);
	endtask

	task automatic test_grade_bands();
		int unsigned peak;
		int unsigned steps[8] = '{90, 80, 72, 60, 70, 75, 84, 95};
		await_drain();
		write_reg(REG_WINDOW_LENGTH, WLEN_TOP);
		write_reg(REG_LOAD_RESISTANCE, LOAD_RESET);
		send_flat_group(500);
		peak = cfg_numer / 500 - cfg_load;
		foreach (steps[i])
			send_flat_group(mean_for_rs(peak * steps[i] / 100));
	endtask

	task automatic test_backpressure();
		await_drain();
		tx_steady = 1'b1;
		hold_request = 1'b1;
		repeat (3) send_flat_group($urandom_range(ADC_TOP, 1));
		tx_steady = 1'b0;
		await_drain();
	endtask

	task automatic send_random_group(input int base);
		int pick, noise, v;
		pick = $urandom_range(99);
		noise = $urandom_range(64, 1);
		for (int i = 0; i < SAMPLES_PER_AVERAGE; i++) begin
			if (pick < 70)
				v = base + int'($urandom_range(2 * noise)) - noise;
			else if (pick < 85)
				v = $urandom_range(ADC_TOP);
			else if (pick < 95)
				v = $urandom_range(1);
			else
				v = ADC_TOP - int'($urandom_range(3));
			if (v < 0)
				v = 0;
			if (v > ADC_TOP)
				v = ADC_TOP;
			send_sample(v[ADC_BITS-1:0]);
		end
	endtask

	task automatic test_random();
		int base, pick;
		base = 1000;
		for (int phase = 0; phase < 4; phase++) begin
			await_drain();
			pick = $urandom_range(9);
			write_reg(REG_WINDOW_LENGTH, (pick == 0) ? 0 : (pick == 1) ? WLEN_TOP :
				$urandom_range(12, 1));
			pick = $urandom_range(9);
			write_reg(REG_RS_NUMERATOR, (pick < 2) ? $urandom_range(NUM_TOP) :
				(pick < 4) ? NUM_RESET : $urandom_range(24000000, 8000000));
			pick = $urandom_range(9);
			write_reg(REG_LOAD_RESISTANCE, (pick == 0) ? LOAD_TOP :
				(pick == 1) ? $urandom_range(LOAD_TOP) : $urandom_range(6000));
			tx_steady = (phase == 2);
			rx_steady = (phase == 2);
			repeat (1) begin
				base = base + int'($urandom_range(600)) - 300;
				if (base < 16)
					base = 16;
				if (base > ADC_TOP)
					base = ADC_TOP;
				send_random_group(base);
			end
			tx_steady = 1'b0;
			rx_steady = 1'b0;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		adc_sample = '0;
		cfg_window = WLEN_RESET;
		cfg_numer = NUM_RESET;
		cfg_load = LOAD_RESET;
		acc_sum = 0;
		acc_count = 0;
		win_count = 0;
		win_peak = 0;
		ref_peak = 0;
		last_rs = 0;
		grade_now = LEVEL_CLEAN;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_register_reset();
		test_zero_mean();
		test_extreme_samples();
		test_saturation_and_floor();
		test_zero_reference();
		test_grade_bands();
		test_backpressure();
		test_random();
		await_drain();

		if (failures == 0 && expected_grades.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== gas_sensor_air_quality_grader_core.f =====
+incdir+rtl
rtl/gsaqg_pkg.sv
rtl/gas_sensor_air_quality_grader_core.sv
dv/tb_top.sv
